// File: hw/rtl/lsbme_pkg.sv
`default_nettype none

package lsbme_pkg;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_PROCESS = 2'd2;

    localparam logic [1:0] CFG_NUM_BITS = 2'd0;
    localparam logic [1:0] CFG_MODE     = 2'd1;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    localparam logic [4:0] MAX_BITS = 5'd16;

    // bytes completed by one word, then the word itself
    typedef struct packed {
        logic [1:0]  nbytes;
        logic [31:0] out_word;
        logic        word_done;
        logic [7:0]  byte0;
        logic [5:0]  idx0;
        logic        done0;
        logic [7:0]  byte1;
        logic [5:0]  idx1;
        logic        done1;
    } lsbme_result_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lsbme_datapath.sv
`default_nettype none

module lsbme_datapath
    import lsbme_pkg::*;
#(
    parameter int MESSAGE_BYTES = 64
) (
    input  wire logic [$clog2(MESSAGE_BYTES * 8 + 1)-1:0] bit_pos,
    input  wire logic [7:0]                               gather,
    input  wire logic [15:0]                              window,
    input  wire logic [4:0]                               num_bits,
    input  wire logic                                     mode,
    input  wire logic [31:0]                              word,
    output lsbme_result_t                                 result,
    output logic [$clog2(MESSAGE_BYTES * 8 + 1)-1:0]      bit_pos_next,
    output logic [7:0]                                    gather_next
);

    localparam int TOTAL_BITS = MESSAGE_BYTES * 8;
    localparam int BP_W = $clog2(TOTAL_BITS + 1);
    localparam int CW = (BP_W > 5) ? BP_W : 5;
    localparam int DW = BP_W + 2;

    logic [4:0]      n_bits;
    logic [BP_W-1:0] remaining;
    logic [4:0]      used;
    logic [16:0]     mask17;
    logic [15:0]     mask;
    logic [15:0]     wm;
    logic [2:0]      off;
    logic [5:0]      span;
    logic [23:0]     seq;
    logic [BP_W-1:0] base;
    logic [BP_W+5:0] bp_ext;
    logic [5:0]      idx0;

    always_comb begin
        if (num_bits == 5'd0) begin
            n_bits = 5'd1;
        end else if (num_bits > MAX_BITS) begin
            n_bits = MAX_BITS;
        end else begin
            n_bits = num_bits;
        end

        remaining = BP_W'(TOTAL_BITS) - bit_pos;
        used = (CW'(remaining) < CW'(n_bits)) ? 5'(remaining) : n_bits;
        mask17 = (17'd1 << used) - 17'd1;
        mask = mask17[15:0];
        bit_pos_next = bit_pos + BP_W'(used);

        off = bit_pos[2:0];
        span = {3'b000, off} + {1'b0, used};
        base = {bit_pos[BP_W-1:3], 3'b000};
        bp_ext = (BP_W + 6)'(bit_pos);
        idx0 = bp_ext[8:3];

        wm = word[15:0] & mask;
        seq = {16'b0, rev8(gather)} | ({8'b0, wm} << off);

        result.byte0 = rev8(seq[7:0]);
        result.byte1 = rev8(seq[15:8]);
        result.idx0 = idx0;
        result.idx1 = idx0 + 6'd1;
        result.done0 = (DW'(base) + DW'(8)) >= DW'(TOTAL_BITS);
        result.done1 = (DW'(base) + DW'(16)) >= DW'(TOTAL_BITS);
        result.word_done = bit_pos_next == BP_W'(TOTAL_BITS);

        if (mode == MODE_EMBED) begin
            result.out_word = {word[31:16], (word[15:0] & ~mask) | (window & mask)};
            result.nbytes = 2'd0;
            gather_next = gather;
        end else begin
            result.out_word = word;
            if (span >= 6'd16) begin
                result.nbytes = 2'd2;
                gather_next = rev8(seq[23:16]);
            end else if (span >= 6'd8) begin
                result.nbytes = 2'd1;
                gather_next = rev8(seq[15:8]);
            end else begin
                result.nbytes = 2'd0;
                gather_next = rev8(seq[7:0]);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lsb_message_embed_extract.sv
`default_nettype none

// channel   direction  ports
// s_        in         s_valid s_ready s_cmd s_msg_byte s_word
// m_        out        m_valid m_ready m_kind m_out_word m_out_byte m_byte_index
//                      m_done_res m_last
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data
//
// one input transaction per cycle unless a processed word waits for the result
// register; a word passes through the input register, then the result register
// a processed word yields one result in embed mode and up to three in extract
// mode, one per cycle unless stalled; the result register then holds the next word
// reset clears positions and config; the message store keeps no reset value
// a stall on m_ holds the result register and backs up into the input register

module lsb_message_embed_extract
    import lsbme_pkg::*;
#(
    parameter int MESSAGE_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_msg_byte,
    input  wire logic [31:0] s_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [31:0]      m_out_word,
    output logic [7:0]       m_out_byte,
    output logic [5:0]       m_byte_index,
    output logic             m_done_res,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    localparam int TOTAL_BITS = MESSAGE_BYTES * 8;
    localparam int BP_W = $clog2(TOTAL_BITS + 1);
    localparam int LP_W = $clog2(MESSAGE_BYTES + 1);

    logic                  in_valid_reg;
    logic [1:0]            in_cmd_reg;
    logic [7:0]            in_byte_reg;
    logic [31:0]           in_word_reg;

    logic [BP_W-1:0]       bit_pos_reg;
    logic [LP_W-1:0]       load_pos_reg;
    logic [7:0]            gather_reg;
    logic [4:0]            num_bits_reg;
    logic                  mode_reg;
    logic [TOTAL_BITS-1:0] msg_reg;

    logic                  grp_valid_reg;
    logic [1:0]            grp_ptr_reg;
    lsbme_result_t         grp_reg;

    lsbme_result_t         result;
    logic [BP_W-1:0]       bit_pos_next;
    logic [7:0]            gather_next;
    logic [15:0]           window;
    logic                  grp_release;
    logic                  fire;
    logic                  out_take;

    assign window = 16'({16'b0, msg_reg} >> bit_pos_reg);

    lsbme_datapath #(
        .MESSAGE_BYTES(MESSAGE_BYTES)
    ) u_datapath (
        .bit_pos     (bit_pos_reg),
        .gather      (gather_reg),
        .window      (window),
        .num_bits    (num_bits_reg),
        .mode        (mode_reg),
        .word        (in_word_reg),
        .result      (result),
        .bit_pos_next(bit_pos_next),
        .gather_next (gather_next)
    );

    assign out_take = grp_valid_reg && m_ready;
    assign grp_release = out_take && (grp_ptr_reg == grp_reg.nbytes);
    assign fire = in_valid_reg
                  && ((in_cmd_reg != CMD_PROCESS) || !grp_valid_reg || grp_release);
    assign s_ready = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_cmd_reg <= s_cmd;
            in_byte_reg <= s_msg_byte;
            in_word_reg <= s_word;
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bits_reg <= 5'd1;
            mode_reg <= MODE_EMBED;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NUM_BITS: num_bits_reg <= cfg_data;
                CFG_MODE:     mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // message positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_pos_reg <= '0;
            load_pos_reg <= '0;
            gather_reg <= 8'd0;
        end else if (fire) begin
            unique case (in_cmd_reg)
                CMD_RESTART: begin
                    bit_pos_reg <= '0;
                    load_pos_reg <= '0;
                    gather_reg <= 8'd0;
                end
                CMD_LOAD: begin
                    if (load_pos_reg < LP_W'(MESSAGE_BYTES)) begin
                        load_pos_reg <= load_pos_reg + LP_W'(1);
                    end
                end
                CMD_PROCESS: begin
                    bit_pos_reg <= bit_pos_next;
                    gather_reg <= gather_next;
                end
                default: ;
            endcase
        end
    end

    // message store, bit p of the message at msg_reg[p]
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MESSAGE_BYTES; i++) begin
            if (fire && (in_cmd_reg == CMD_LOAD) && (load_pos_reg == LP_W'(i))) begin
                msg_reg[i * 8 +: 8] <= rev8(in_byte_reg);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
            grp_ptr_reg <= 2'd0;
        end else if (fire && (in_cmd_reg == CMD_PROCESS)) begin
            grp_valid_reg <= 1'b1;
            grp_ptr_reg <= 2'd0;
        end else if (grp_release) begin
            grp_valid_reg <= 1'b0;
        end else if (out_take) begin
            grp_ptr_reg <= grp_ptr_reg + 2'd1;
        end
        if (fire && (in_cmd_reg == CMD_PROCESS)) begin
            grp_reg <= result;
        end
    end

    always_comb begin
        m_valid = grp_valid_reg;
        if (grp_ptr_reg == grp_reg.nbytes) begin
            m_kind = KIND_WORD;
            m_out_word = grp_reg.out_word;
            m_out_byte = 8'd0;
            m_byte_index = 6'd0;
            m_done_res = grp_reg.word_done;
            m_last = 1'b1;
        end else if (grp_ptr_reg == 2'd0) begin
            m_kind = KIND_BYTE;
            m_out_word = 32'd0;
            m_out_byte = grp_reg.byte0;
            m_byte_index = grp_reg.idx0;
            m_done_res = grp_reg.done0;
            m_last = 1'b0;
        end else begin
            m_kind = KIND_BYTE;
            m_out_word = 32'd0;
            m_out_byte = grp_reg.byte1;
            m_byte_index = grp_reg.idx1;
            m_done_res = grp_reg.done1;
            m_last = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/lsb_message_embed_extract_tb.sv
`default_nettype none

module lsb_message_embed_extract_tb;
    import lsbme_pkg::*;

    localparam int MSG_BYTES = 64;
    localparam int MSG_BITS  = MSG_BYTES * 8;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [1:0] CFG_UNUSED_B = 2'd3;

    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  msg_byte;
        logic [31:0] word;
    } steg_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] out_word;
        logic [7:0]  out_byte;
        logic [5:0]  byte_index;
        logic        done_res;
        logic        last;
    } steg_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_RESTART;
    logic [7:0]  s_msg_byte = 8'h00;
    logic [31:0] s_word = 32'h0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [31:0] m_out_word;
    logic [7:0]  m_out_byte;
    logic [5:0]  m_byte_index;
    logic        m_done_res;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_NUM_BITS;
    logic [4:0]  cfg_data = 5'd0;

    // shadow of the block state
    logic [7:0]  msg_store [MSG_BYTES];
    logic [9:0]  bits_used = '0;
    logic [6:0]  bytes_loaded = '0;
    logic [7:0]  partial_byte = '0;
    logic [4:0]  cfg_nbits = 5'd1;
    logic        cfg_mode = MODE_EMBED;

    steg_item_t   send_q[$];
    steg_result_t expected_results[$];

    int items_outstanding = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_no = 0;
    int error_count = 0;
    int accepted_count = 0;
    int results_checked = 0;
    int bytes_checked = 0;
    int done_checked = 0;

    lsb_message_embed_extract #(
        .MESSAGE_BYTES(MSG_BYTES)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_msg_byte  (s_msg_byte),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_out_word  (m_out_word),
        .m_out_byte  (m_out_byte),
        .m_byte_index(m_byte_index),
        .m_done_res  (m_done_res),
        .m_last      (m_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_checked, name, got, want));
        end
    endtask

    function automatic void push_result(input logic kind, input logic [31:0] w,
                                        input logic [7:0] b, input logic [5:0] idx,
                                        input logic last);
        steg_result_t r;
        r.kind       = kind;
        r.out_word   = w;
        r.out_byte   = b;
        r.byte_index = idx;
        r.done_res   = (bits_used >= MSG_BITS);
        r.last       = last;
        expected_results.push_back(r);
    endfunction

    // advance the shadow state by one input transaction
    function automatic void embed_extract_step(input steg_item_t it);
        int n;
        logic [9:0]  byte_no;
        logic [2:0]  shift;
        logic        msg_bit;
        logic [31:0] w;
        w = it.word;
        case (it.cmd)
            CMD_RESTART: begin
                bits_used    = '0;
                bytes_loaded = '0;
                partial_byte = '0;
            end
            CMD_LOAD: begin
                if (bytes_loaded < MSG_BYTES) begin
                    msg_store[bytes_loaded[5:0]] = it.msg_byte;
                    bytes_loaded++;
                end
            end
            CMD_PROCESS: begin
                n = (cfg_nbits == 5'd0) ? 1 : (cfg_nbits > MAX_BITS) ? MAX_BITS : cfg_nbits;
                for (int k = 0; k < n; k++) begin
                    if (bits_used >= MSG_BITS) begin
                        break;
                    end
                    byte_no = bits_used >> 3;
                    shift   = 3'd7 - bits_used[2:0];
                    if (cfg_mode == MODE_EMBED) begin
                        msg_bit = msg_store[byte_no[5:0]][shift];
                        w[k] = msg_bit;
                        bits_used++;
                    end else begin
                        partial_byte[shift] = partial_byte[shift] | w[k];
                        bits_used++;
                        if (shift == 3'd0) begin
                            push_result(KIND_BYTE, 32'h0, partial_byte, byte_no[5:0], 1'b0);
                            partial_byte = '0;
                        end
                    end
                end
                push_result(KIND_WORD, w, 8'h00, 6'd0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin : driver
        steg_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                embed_extract_step({s_cmd, s_msg_byte, s_word});
                items_outstanding--;
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = send_q.pop_front();
                    s_valid    <= 1'b1;
                    s_cmd      <= nxt.cmd;
                    s_msg_byte <= nxt.msg_byte;
                    s_word     <= nxt.word;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        steg_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d word %0h byte %0h",
                                              m_kind, m_out_word, m_out_byte));
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(m_kind), 32'(want.kind));
                    check_field("out_word", m_out_word, want.out_word);
                    check_field("out_byte", 32'(m_out_byte), 32'(want.out_byte));
                    check_field("byte_index", 32'(m_byte_index), 32'(want.byte_index));
                    check_field("done_res", 32'(m_done_res), 32'(want.done_res));
                    check_field("last", 32'(m_last), 32'(want.last));
                    if (want.kind == KIND_BYTE) begin
                        bytes_checked++;
                    end
                    if (want.done_res) begin
                        done_checked++;
                    end
                    results_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void queue_item(input logic [1:0] cmd, input logic [7:0] b,
                                       input logic [31:0] w);
        steg_item_t it;
        it.cmd      = cmd;
        it.msg_byte = b;
        it.word     = w;
        send_q.push_back(it);
        items_outstanding++;
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 32'h0000_0000;
        end else if (r == 1) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NUM_BITS) begin
            cfg_nbits = val;
        end else if (idx == CFG_MODE) begin
            cfg_mode = val[0];
        end
    endtask

    // everything sent and every result back, then let the pipeline settle
    task automatic wait_idle();
        while (items_outstanding != 0 || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_phase(input logic [4:0] nbits, input logic mode);
        logic [4:0] mode_val;
        wait_idle();
        mode_val    = 5'($urandom);
        mode_val[0] = mode;
        write_reg(CFG_NUM_BITS, nbits);
        write_reg(CFG_MODE, mode_val);
        case (phase_no % 4)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 70;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 70;
            end
            default: begin
                send_idle_pct = 25;
                recv_stall_pct = 25;
            end
        endcase
        phase_no++;
    endtask

    initial begin : stimulus
        int rand_items;
        int n_eff;
        int n_words;
        int n_loads;
        int r;
        logic [4:0] nbits;
        logic [7:0] fill;

        rand_items = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // smallest width, embed; fill the whole store first
        set_phase(5'd1, MODE_EMBED);
        for (int i = 0; i < MSG_BYTES; i++) begin
            case (i)
                0: fill = 8'h00;
                1: fill = 8'hFF;
                2: fill = 8'h80;
                3: fill = 8'h01;
                default: fill = 8'($urandom);
            endcase
            queue_item(CMD_LOAD, fill, rand_word());
        end
        queue_item(CMD_LOAD, 8'hAA, 32'hFFFF_FFFF);
        queue_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_PROCESS, 8'h00, 32'h0000_0000);
        queue_item(CMD_PROCESS, 8'hFF, 32'hFFFF_FFFF);
        queue_item(CMD_PROCESS, 8'($urandom), $urandom);

        // widest setting, extract from a fresh start
        set_phase(5'd16, MODE_EXTRACT);
        queue_item(CMD_RESTART, 8'($urandom), $urandom);
        queue_item(CMD_PROCESS, 8'($urandom), 32'hFFFF_FFFF);
        queue_item(CMD_PROCESS, 8'($urandom), 32'h0000_0000);
        queue_item(CMD_PROCESS, 8'($urandom), 32'h5A5A_A5A5);
        queue_item(CMD_PROCESS, 8'($urandom), $urandom);

        // switch to embed mid-message, position carries on
        set_phase(5'd16, MODE_EMBED);
        queue_item(CMD_PROCESS, 8'($urandom), 32'hFFFF_FFFF);
        queue_item(CMD_PROCESS, 8'($urandom), 32'h0000_0000);

        // zero width behaves as one; writes to unknown registers are dropped
        set_phase(5'd0, MODE_EXTRACT);
        write_reg(CFG_UNUSED_A, 5'd31);
        write_reg(CFG_UNUSED_B, 5'd0);
        queue_item(CMD_PROCESS, 8'($urandom), 32'hFFFF_FFFF);
        queue_item(CMD_PROCESS, 8'($urandom), 32'h0000_0000);

        // oversized width clamps to 16; embed straight after restart, no loads
        set_phase(5'd31, MODE_EMBED);
        queue_item(CMD_RESTART, 8'($urandom), $urandom);
        queue_item(CMD_PROCESS, 8'($urandom), 32'h0000_0000);
        queue_item(CMD_PROCESS, 8'($urandom), 32'hFFFF_FFFF);
        queue_item(CMD_PROCESS, 8'($urandom), $urandom);

        // random messages, mostly well formed, some noise
        while (rand_items < 220) begin
            r = $urandom_range(9);
            if (r == 0) begin
                nbits = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(31, 17));
            end else if (r < 3) begin
                nbits = 5'($urandom_range(7, 1));
            end else begin
                nbits = 5'($urandom_range(16, 8));
            end
            set_phase(nbits, 1'($urandom_range(1)));
            n_eff = (nbits == 0) ? 1 : (nbits > MAX_BITS) ? MAX_BITS : nbits;

            if ($urandom_range(4) != 0) begin
                queue_item(CMD_RESTART, 8'($urandom), $urandom);
                rand_items++;
            end
            n_loads = ($urandom_range(5) == 0) ? MSG_BYTES : $urandom_range(16);
            for (int i = 0; i < n_loads; i++) begin
                queue_item(CMD_LOAD, 8'($urandom), $urandom);
                rand_items++;
            end
            if (n_eff >= 8) begin
                n_words = (MSG_BITS + n_eff - 1) / n_eff + $urandom_range(4);
            end else begin
                n_words = $urandom_range(40, 8);
            end
            for (int i = 0; i < n_words; i++) begin
                r = $urandom_range(99);
                if (r < 4) begin
                    queue_item(CMD_UNUSED, 8'($urandom), $urandom);
                end else if (r < 7) begin
                    queue_item(CMD_LOAD, 8'($urandom), $urandom);
                    rand_items++;
                end else if (r < 9) begin
                    queue_item(CMD_RESTART, 8'($urandom), $urandom);
                    rand_items++;
                end
                queue_item(CMD_PROCESS, 8'($urandom), rand_word());
                rand_items++;
            end
        end

        while (items_outstanding != 0) begin
            @(posedge aclk);
        end
        for (int c = 0; c < 5000 && expected_results.size() != 0; c++) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end

        $display("run: %0d input transactions, %0d results checked, %0d extracted bytes,",
                 accepted_count, results_checked, bytes_checked);
        $display("     %0d results after message end, %0d phases, %0d errors",
                 done_checked, phase_no, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #6_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
